@@ hdl/dfr_pkg.sv @@
package dfr_pkg;

  localparam int LAST_SLOT_DEF       = 512;
  localparam int LAMP_FULL_SCALE_DEF = 1999;

  localparam int BYTE_W   = 8;
  localparam int ADDR_W   = 10;
  localparam int CENTER_W = 15;
  localparam int TIMER_W  = 24;
  localparam int LEVEL_W  = 16;
  localparam int LAMP_W   = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int LFS_W    = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [TIMER_W-1:0] TIMER_MAX  = '1;
  localparam logic [TIMER_W-1:0] IDLE_RESET = 24'd1000000;
  localparam logic [LAMP_W-1:0]  STATUS_ON  = 11'd1999;
  localparam logic [LAMP_W-1:0]  LAMP_SAT   = 11'd2047;

  localparam logic [ADDR_W-1:0]   START_ADDRESS_RST     = 10'd1;
  localparam logic [CENTER_W-1:0] CENTER_RST            = 15'd1500;
  localparam logic [CENTER_W-1:0] RANGE_RST             = 15'd1000;
  localparam logic [TIMER_W-1:0]  ACTIVITY_TIMEOUT_RST  = 24'd1000000;
  localparam logic [TIMER_W-1:0]  BLINK_HALF_PERIOD_RST = 24'd500000;

  // divide by 255: x * (2^24 - 1) / (255 * 2^24) undershoots by less than one
  localparam int DIV_W       = 32;
  localparam int QUOT_W      = 25;
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP_255 = 17'd65793;
  localparam logic [DIV_W:0]     DIVISOR   = 33'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_ADDRESS,
    REG_PAN_CENTER,
    REG_PAN_RANGE,
    REG_TILT_CENTER,
    REG_TILT_RANGE,
    REG_SWAP_AXES,
    REG_ACTIVITY_TIMEOUT,
    REG_BLINK_HALF_PERIOD
  } cfg_reg_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   start_address;
    logic [CENTER_W-1:0] pan_center;
    logic [CENTER_W-1:0] pan_range;
    logic [CENTER_W-1:0] tilt_center;
    logic [CENTER_W-1:0] tilt_range;
    logic                swap_axes;
    logic [TIMER_W-1:0]  activity_timeout;
    logic [TIMER_W-1:0]  blink_half_period;
  } cfg_t;

  typedef enum logic [1:0] {
    CMD_TICK,
    CMD_BREAK,
    CMD_CHAR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] data;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV_A,
    BK_DIV_B,
    BK_DIV_C,
    BK_DIV_D,
    BK_OUT
  } back_state_t;

  // quotient estimate, equal to floor(x/255) or one below
  function automatic logic [QUOT_W-1:0] div255_est(logic [DIV_W-1:0] x);
    logic [DIV_W+RECIP_W-1:0] p;
    p = {{RECIP_W{1'b0}}, x} * {{DIV_W{1'b0}}, RECIP_255};
    return p[RECIP_SHIFT +: QUOT_W];
  endfunction

  function automatic logic [QUOT_W-1:0] div255_fix(logic [DIV_W-1:0] x,
                                                   logic [QUOT_W-1:0] q0);
    logic [DIV_W:0] q_ext;
    logic [DIV_W:0] rem;
    q_ext = {{(DIV_W+1-QUOT_W){1'b0}}, q0};
    rem   = {1'b0, x} - ((q_ext << 8) - q_ext);
    return (rem >= DIVISOR) ? q0 + 1'b1 : q0;
  endfunction

endpackage

@@ hdl/dfr_in_if.sv @@
interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;
  logic       framing_error;

  modport source (output valid, output op, output rx_byte, output framing_error,
                  input ready);
  modport sink (input valid, input op, input rx_byte, input framing_error,
                output ready);
endinterface

@@ hdl/dfr_out_if.sv @@
interface dfr_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] servo_one_level;
  logic [15:0] servo_two_level;
  logic [10:0] lamp_level;
  logic [10:0] status_level;
  logic        link_active;

  modport source (output valid, output servo_one_level, output servo_two_level,
                  output lamp_level, output status_level, output link_active,
                  input ready);
  modport sink (input valid, input servo_one_level, input servo_two_level,
                input lamp_level, input status_level, input link_active,
                output ready);
endinterface

@@ hdl/dfr_cfg_if.sv @@
interface dfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/dmx_fixture_receiver.sv @@
// DMX512 fixture receiver for a pan/tilt/dimmer head. Each input transfer is a
// received character (with its framing-error flag, which marks a break) or a
// one-microsecond tick, and each produces exactly one result transfer carrying
// both servo levels, the lamp level, the status LED level and the link flag.
// The front end takes an input transfer whenever its two-entry command queue
// has room. A result waiting in the output register stalls the back end, and
// input is held off once the queue has filled behind it. The back end works
// one command at a time: BK_IDLE updates slot counter, captured slots and
// timers, BK_MUL and BK_DIV_A to BK_DIV_D do the multiply and divide-by-255
// steps that scale the axes and the lamp curve, and BK_OUT loads the output
// register. After reset the link is inactive and the slot counter waits for
// the first break. Configuration writes are taken in every cycle and belong in
// periods with no transfer in flight.
module dmx_fixture_receiver #(
  parameter int LAST_SLOT       = dfr_pkg::LAST_SLOT_DEF,
  parameter int LAMP_FULL_SCALE = dfr_pkg::LAMP_FULL_SCALE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dfr_in_if.sink    in_ch,
  dfr_out_if.source out_ch,
  dfr_cfg_if.sink   cfg_ch
);
  import dfr_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic push;
  logic q_full;
  logic pop;
  logic head_valid;

  dfr_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  dfr_front u_front (
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  dfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  dfr_back #(
    .LAST_SLOT       (LAST_SLOT),
    .LAMP_FULL_SCALE (LAMP_FULL_SCALE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

@@ hdl/dfr_cfg_regs.sv @@
module dfr_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  dfr_cfg_if.sink       cfg_ch,
  output dfr_pkg::cfg_t cfg
);
  import dfr_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_START_ADDRESS:     cfg_nxt.start_address     = cfg_ch.data[ADDR_W-1:0];
        REG_PAN_CENTER:        cfg_nxt.pan_center        = cfg_ch.data[CENTER_W-1:0];
        REG_PAN_RANGE:         cfg_nxt.pan_range         = cfg_ch.data[CENTER_W-1:0];
        REG_TILT_CENTER:       cfg_nxt.tilt_center       = cfg_ch.data[CENTER_W-1:0];
        REG_TILT_RANGE:        cfg_nxt.tilt_range        = cfg_ch.data[CENTER_W-1:0];
        REG_SWAP_AXES:         cfg_nxt.swap_axes         = cfg_ch.data[0];
        REG_ACTIVITY_TIMEOUT:  cfg_nxt.activity_timeout  = cfg_ch.data[TIMER_W-1:0];
        REG_BLINK_HALF_PERIOD: cfg_nxt.blink_half_period = cfg_ch.data[TIMER_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_address     <= START_ADDRESS_RST;
      cfg_r.pan_center        <= CENTER_RST;
      cfg_r.pan_range         <= RANGE_RST;
      cfg_r.tilt_center       <= CENTER_RST;
      cfg_r.tilt_range        <= RANGE_RST;
      cfg_r.swap_axes         <= 1'b0;
      cfg_r.activity_timeout  <= ACTIVITY_TIMEOUT_RST;
      cfg_r.blink_half_period <= BLINK_HALF_PERIOD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ hdl/dfr_front.sv @@
module dfr_front (
  dfr_in_if.sink        in_ch,
  input  logic          q_full,
  output logic          push,
  output dfr_pkg::cmd_t push_cmd
);
  import dfr_pkg::*;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // a tick ignores the character fields; a break discards the character
  always_comb begin
    push_cmd.data = in_ch.rx_byte;
    priority if (in_ch.op) begin
      push_cmd.kind = CMD_TICK;
    end else if (in_ch.framing_error) begin
      push_cmd.kind = CMD_BREAK;
    end else begin
      push_cmd.kind = CMD_CHAR;
    end
  end

endmodule

@@ hdl/dfr_queue.sv @@
module dfr_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dfr_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output dfr_pkg::cmd_t head_cmd
);
  import dfr_pkg::*;

  cmd_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

@@ hdl/dfr_back.sv @@
module dfr_back #(
  parameter int LAST_SLOT       = dfr_pkg::LAST_SLOT_DEF,
  parameter int LAMP_FULL_SCALE = dfr_pkg::LAMP_FULL_SCALE_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  dfr_pkg::cfg_t cfg,
  input  logic          head_valid,
  input  dfr_pkg::cmd_t head_cmd,
  output logic          pop,
  dfr_out_if.source     out_ch
);
  import dfr_pkg::*;

  localparam int SLOT_W = $clog2(LAST_SLOT + 2);
  localparam logic [SLOT_W-1:0] SLOT_IDLE = SLOT_W'(LAST_SLOT + 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(LAST_SLOT);
  localparam logic [ADDR_W-1:0] ADDR_HI   = ADDR_W'(LAST_SLOT - 2);
  localparam logic [LFS_W-1:0]  LFS       = LFS_W'(LAMP_FULL_SCALE);
  localparam int PROD_W = 25;

  back_state_t state_r, state_nxt;

  // link and slot state
  logic [SLOT_W-1:0]  slot_r, slot_nxt;
  logic [BYTE_W-1:0]  start_code_r, start_code_nxt;
  logic [BYTE_W-1:0]  pan_byte_r, pan_byte_nxt;
  logic [BYTE_W-1:0]  tilt_byte_r, tilt_byte_nxt;
  logic [BYTE_W-1:0]  dim_byte_r, dim_byte_nxt;
  logic [TIMER_W-1:0] idle_r, idle_nxt;
  logic [TIMER_W-1:0] blink_r, blink_nxt;
  logic               led_r, led_nxt;
  logic               lit_r, lit_nxt;
  logic               active_r, active_nxt;
  logic [LEVEL_W-1:0] s1_held_r, s1_held_nxt;
  logic [LEVEL_W-1:0] s2_held_r, s2_held_nxt;
  logic [LAMP_W-1:0]  lamp_held_r, lamp_held_nxt;

  // arithmetic stages
  logic signed [PROD_W-1:0] pan_prod_r, pan_prod_nxt;
  logic signed [PROD_W-1:0] tilt_prod_r, tilt_prod_nxt;
  logic [2*BYTE_W-1:0]      dsq_r, dsq_nxt;
  logic [QUOT_W-1:0]        pan_q0_r, pan_q0_nxt;
  logic [QUOT_W-1:0]        tilt_q0_r, tilt_q0_nxt;
  logic [LEVEL_W-1:0]       pan_lvl_r, pan_lvl_nxt;
  logic [LEVEL_W-1:0]       tilt_lvl_r, tilt_lvl_nxt;
  logic [DIV_W-1:0]         lprod_r, lprod_nxt;
  logic [QUOT_W-1:0]        lq0_r, lq0_nxt;
  logic [QUOT_W-1:0]        lq1_r, lq1_nxt;
  logic [QUOT_W-1:0]        lq2_r, lq2_nxt;

  // result register
  logic               out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0] out_s1_r, out_s1_nxt;
  logic [LEVEL_W-1:0] out_s2_r, out_s2_nxt;
  logic [LAMP_W-1:0]  out_lamp_r, out_lamp_nxt;
  logic [LAMP_W-1:0]  out_status_r, out_status_nxt;
  logic               out_active_r, out_active_nxt;

  logic [TIMER_W-1:0]       idle_t, blink_t;
  logic                     active_t;
  logic signed [BYTE_W:0]   pan_off, tilt_off;
  logic [PROD_W-1:0]        pan_mag, tilt_mag;
  logic [QUOT_W-1:0]        pan_q, tilt_q, lamp_q;
  logic [LEVEL_W-1:0]       pan_ofs16, tilt_ofs16;
  logic [ADDR_W:0]          slot_ext;
  logic                     addr_ok;
  logic [LAMP_W-1:0]        lamp_sat;

  assign pan_off  = $signed({1'b0, pan_byte_r}) - 9'sd127;
  assign tilt_off = $signed({1'b0, tilt_byte_r}) - 9'sd127;
  assign pan_mag  = pan_prod_r[PROD_W-1] ? PROD_W'(-pan_prod_r) : PROD_W'(pan_prod_r);
  assign tilt_mag = tilt_prod_r[PROD_W-1] ? PROD_W'(-tilt_prod_r) : PROD_W'(tilt_prod_r);
  assign pan_q    = div255_fix(DIV_W'(pan_mag), pan_q0_r);
  assign tilt_q   = div255_fix(DIV_W'(tilt_mag), tilt_q0_r);
  assign pan_ofs16  = pan_prod_r[PROD_W-1] ? -pan_q[LEVEL_W-1:0] : pan_q[LEVEL_W-1:0];
  assign tilt_ofs16 = tilt_prod_r[PROD_W-1] ? -tilt_q[LEVEL_W-1:0] : tilt_q[LEVEL_W-1:0];
  assign lamp_q   = div255_fix(DIV_W'(lq1_r), lq2_r);
  assign lamp_sat = (lamp_q > QUOT_W'(LAMP_SAT)) ? LAMP_SAT : lamp_q[LAMP_W-1:0];
  assign slot_ext = (ADDR_W+1)'(slot_r);
  assign addr_ok  = (cfg.start_address != '0) && (cfg.start_address <= ADDR_HI);

  assign out_ch.valid           = out_valid_r;
  assign out_ch.servo_one_level = out_s1_r;
  assign out_ch.servo_two_level = out_s2_r;
  assign out_ch.lamp_level      = out_lamp_r;
  assign out_ch.status_level    = out_status_r;
  assign out_ch.link_active     = out_active_r;

  always_comb begin
    state_nxt      = state_r;
    pop            = 1'b0;
    slot_nxt       = slot_r;
    start_code_nxt = start_code_r;
    pan_byte_nxt   = pan_byte_r;
    tilt_byte_nxt  = tilt_byte_r;
    dim_byte_nxt   = dim_byte_r;
    idle_nxt       = idle_r;
    blink_nxt      = blink_r;
    led_nxt        = led_r;
    lit_nxt        = lit_r;
    active_nxt     = active_r;
    s1_held_nxt    = s1_held_r;
    s2_held_nxt    = s2_held_r;
    lamp_held_nxt  = lamp_held_r;
    pan_prod_nxt   = pan_prod_r;
    tilt_prod_nxt  = tilt_prod_r;
    dsq_nxt        = dsq_r;
    pan_q0_nxt     = pan_q0_r;
    tilt_q0_nxt    = tilt_q0_r;
    pan_lvl_nxt    = pan_lvl_r;
    tilt_lvl_nxt   = tilt_lvl_r;
    lprod_nxt      = lprod_r;
    lq0_nxt        = lq0_r;
    lq1_nxt        = lq1_r;
    lq2_nxt        = lq2_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_s1_nxt     = out_s1_r;
    out_s2_nxt     = out_s2_r;
    out_lamp_nxt   = out_lamp_r;
    out_status_nxt = out_status_r;
    out_active_nxt = out_active_r;
    idle_t         = idle_r;
    blink_t        = blink_r;
    active_t       = active_r;

    unique case (state_r)
      BK_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          unique case (head_cmd.kind)
            CMD_TICK: begin
              if (idle_t != TIMER_MAX) idle_t = idle_r + 1'b1;
              if (blink_t != TIMER_MAX) blink_t = blink_r + 1'b1;
            end
            CMD_BREAK: slot_nxt = '0;
            CMD_CHAR: begin
              // characters past the last slot wait for the next break
              if (slot_r <= SLOT_LAST) begin
                if (slot_r == '0) begin
                  start_code_nxt = head_cmd.data;
                end else begin
                  priority if (slot_ext == {1'b0, cfg.start_address}) begin
                    pan_byte_nxt = head_cmd.data;
                  end else if (slot_ext == {1'b0, cfg.start_address} + 1'b1) begin
                    tilt_byte_nxt = head_cmd.data;
                  end else if (slot_ext == {1'b0, cfg.start_address} + 2'd2) begin
                    dim_byte_nxt = head_cmd.data;
                  end else begin
                    dim_byte_nxt = dim_byte_r;
                  end
                  idle_t = '0;
                end
                slot_nxt = slot_r + 1'b1;
              end
            end
            default: slot_nxt = slot_r;
          endcase
          active_t = idle_t < cfg.activity_timeout;
          if (active_t) begin
            if (blink_t > cfg.blink_half_period) begin
              led_nxt = !led_r;
              lit_nxt = !led_r;
              blink_t = '0;
            end
          end else begin
            lit_nxt = 1'b0;
          end
          idle_nxt   = idle_t;
          blink_nxt  = blink_t;
          active_nxt = active_t;
          state_nxt  = BK_MUL;
        end
      end
      BK_MUL: begin
        pan_prod_nxt  = pan_off * $signed({1'b0, cfg.pan_range});
        tilt_prod_nxt = tilt_off * $signed({1'b0, cfg.tilt_range});
        dsq_nxt       = dim_byte_r * dim_byte_r;
        state_nxt     = BK_DIV_A;
      end
      BK_DIV_A: begin
        pan_q0_nxt  = div255_est(DIV_W'(pan_mag));
        tilt_q0_nxt = div255_est(DIV_W'(tilt_mag));
        lprod_nxt   = {{(DIV_W-2*BYTE_W){1'b0}}, dsq_r} * {{(DIV_W-LFS_W){1'b0}}, LFS};
        state_nxt   = BK_DIV_B;
      end
      BK_DIV_B: begin
        pan_lvl_nxt  = {1'b0, cfg.pan_center} + pan_ofs16;
        tilt_lvl_nxt = {1'b0, cfg.tilt_center} + tilt_ofs16;
        lq0_nxt      = div255_est(lprod_r);
        state_nxt    = BK_DIV_C;
      end
      BK_DIV_C: begin
        lq1_nxt   = div255_fix(lprod_r, lq0_r);
        state_nxt = BK_DIV_D;
      end
      BK_DIV_D: begin
        // second divide by 255 gives floor of the division by 65025
        lq2_nxt   = div255_est(DIV_W'(lq1_r));
        state_nxt = BK_OUT;
      end
      BK_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          if (active_r && start_code_r == '0) begin
            if (addr_ok) begin
              s1_held_nxt   = cfg.swap_axes ? tilt_lvl_r : pan_lvl_r;
              s2_held_nxt   = cfg.swap_axes ? pan_lvl_r : tilt_lvl_r;
              lamp_held_nxt = lamp_sat;
            end
          end else if (!active_r) begin
            s1_held_nxt   = cfg.swap_axes ? {1'b0, cfg.tilt_center} : {1'b0, cfg.pan_center};
            s2_held_nxt   = cfg.swap_axes ? {1'b0, cfg.pan_center} : {1'b0, cfg.tilt_center};
            lamp_held_nxt = '0;
          end
          out_valid_nxt  = 1'b1;
          out_s1_nxt     = s1_held_nxt;
          out_s2_nxt     = s2_held_nxt;
          out_lamp_nxt   = lamp_held_nxt;
          out_status_nxt = lit_r ? STATUS_ON : '0;
          out_active_nxt = active_r;
          state_nxt      = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      slot_r       <= SLOT_IDLE;
      start_code_r <= '0;
      pan_byte_r   <= '0;
      tilt_byte_r  <= '0;
      dim_byte_r   <= '0;
      idle_r       <= IDLE_RESET;
      blink_r      <= '0;
      led_r        <= 1'b0;
      lit_r        <= 1'b0;
      active_r     <= 1'b0;
      s1_held_r    <= '0;
      s2_held_r    <= '0;
      lamp_held_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slot_r       <= slot_nxt;
      start_code_r <= start_code_nxt;
      pan_byte_r   <= pan_byte_nxt;
      tilt_byte_r  <= tilt_byte_nxt;
      dim_byte_r   <= dim_byte_nxt;
      idle_r       <= idle_nxt;
      blink_r      <= blink_nxt;
      led_r        <= led_nxt;
      lit_r        <= lit_nxt;
      active_r     <= active_nxt;
      s1_held_r    <= s1_held_nxt;
      s2_held_r    <= s2_held_nxt;
      lamp_held_r  <= lamp_held_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pan_prod_r   <= pan_prod_nxt;
    tilt_prod_r  <= tilt_prod_nxt;
    dsq_r        <= dsq_nxt;
    pan_q0_r     <= pan_q0_nxt;
    tilt_q0_r    <= tilt_q0_nxt;
    pan_lvl_r    <= pan_lvl_nxt;
    tilt_lvl_r   <= tilt_lvl_nxt;
    lprod_r      <= lprod_nxt;
    lq0_r        <= lq0_nxt;
    lq1_r        <= lq1_nxt;
    lq2_r        <= lq2_nxt;
    out_s1_r     <= out_s1_nxt;
    out_s2_r     <= out_s2_nxt;
    out_lamp_r   <= out_lamp_nxt;
    out_status_r <= out_status_nxt;
    out_active_r <= out_active_nxt;
  end

  a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slot_r <= SLOT_IDLE)
    else $error("slot counter beyond idle value");

  a_lit_needs_link: assert property (@(posedge clk) disable iff (!rst_n)
    lit_r |-> active_r)
    else $error("status lit while link inactive");

  a_break_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head_cmd.kind == CMD_BREAK) |=> (slot_r == '0))
    else $error("break did not restart slot counter");

  a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (state_r == BK_IDLE) ##1 (state_r == BK_MUL))
    else $error("command taken outside idle state");

endmodule
